// ===== rtl/bdf_pkg.sv =====
// Shared types, constants, font tables and decode functions for the big digit font renderer.
`default_nettype none

package bdf_pkg;

  // Character and cell codes
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_F      = 8'h46;
  localparam logic [7:0] CHAR_L      = 8'h4C;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CODE_BLANK  = 8'd254;
  localparam logic [7:0] CODE_SOLID  = 8'd255;
  localparam logic [3:0] GLYPH_C     = 4'd10;
  localparam logic [3:0] GLYPH_F     = 4'd11;
  localparam logic [3:0] GLYPH_L     = 4'd12;
  localparam logic [3:0] GLYPH_G     = 4'd13;
  localparam logic [3:0] GLYPH_BLANK = 4'd14;
  localparam logic [1:0] PUNCT_NONE  = 2'd0;
  localparam logic [1:0] PUNCT_DOT   = 2'd1;
  localparam logic [1:0] PUNCT_COLON = 2'd2;

  // Glyph tables, row-major within a glyph
  localparam logic [7:0] G2X2 [15][4] = '{
    '{8'd7, 8'd255, 8'd2, 8'd255}, '{8'd254, 8'd255, 8'd254, 8'd255},
    '{8'd1, 8'd6, 8'd255, 8'd3},   '{8'd1, 8'd6, 8'd3, 8'd255},
    '{8'd2, 8'd255, 8'd254, 8'd255}, '{8'd5, 8'd1, 8'd3, 8'd255},
    '{8'd5, 8'd1, 8'd2, 8'd255},   '{8'd4, 8'd6, 8'd254, 8'd255},
    '{8'd5, 8'd6, 8'd5, 8'd6},     '{8'd5, 8'd6, 8'd254, 8'd255},
    '{8'd7, 8'd4, 8'd2, 8'd3},     '{8'd255, 8'd1, 8'd255, 8'd254},
    '{8'd255, 8'd254, 8'd255, 8'd3}, '{8'd7, 8'd4, 8'd2, 8'd6},
    '{8'd254, 8'd254, 8'd254, 8'd254}
  };

  localparam logic [7:0] P2X2 [3][2] = '{
    '{8'd254, 8'd254}, '{8'd254, 8'd0}, '{8'd0, 8'd0}
  };

  localparam logic [7:0] G3X4 [15][12] = '{
    '{8'd4, 8'd1, 8'd5, 8'd255, 8'd254, 8'd255, 8'd255, 8'd254, 8'd255, 8'd6, 8'd2, 8'd7},
    '{8'd254, 8'd255, 8'd254, 8'd254, 8'd255, 8'd254,
      8'd254, 8'd255, 8'd254, 8'd254, 8'd255, 8'd254},
    '{8'd4, 8'd1, 8'd5, 8'd254, 8'd2, 8'd7, 8'd4, 8'd1, 8'd254, 8'd255, 8'd2, 8'd2},
    '{8'd4, 8'd1, 8'd5, 8'd254, 8'd2, 8'd7, 8'd254, 8'd254, 8'd5, 8'd6, 8'd2, 8'd7},
    '{8'd255, 8'd254, 8'd255, 8'd255, 8'd2, 8'd255,
      8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd255},
    '{8'd255, 8'd1, 8'd1, 8'd255, 8'd254, 8'd254, 8'd1, 8'd1, 8'd5, 8'd2, 8'd2, 8'd7},
    '{8'd4, 8'd1, 8'd5, 8'd255, 8'd254, 8'd254, 8'd255, 8'd1, 8'd5, 8'd6, 8'd2, 8'd7},
    '{8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd255,
      8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd255},
    '{8'd4, 8'd1, 8'd5, 8'd6, 8'd2, 8'd7, 8'd4, 8'd1, 8'd5, 8'd6, 8'd2, 8'd7},
    '{8'd4, 8'd1, 8'd5, 8'd6, 8'd2, 8'd255, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd255},
    '{8'd4, 8'd1, 8'd5, 8'd255, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd6, 8'd2, 8'd7},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd2, 8'd2, 8'd255, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254},
    '{8'd255, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254,
      8'd255, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255},
    '{8'd4, 8'd1, 8'd5, 8'd255, 8'd254, 8'd254, 8'd255, 8'd3, 8'd255, 8'd6, 8'd2, 8'd7},
    '{8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
      8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254}
  };

  localparam logic [7:0] P3X4 [3][4] = '{
    '{8'd254, 8'd254, 8'd254, 8'd254}, '{8'd254, 8'd254, 8'd254, 8'd0},
    '{8'd254, 8'd0, 8'd0, 8'd254}
  };

  // Payload types
  typedef struct packed {
    logic [7:0] text_char;
    logic [1:0] origin_row;
    logic [7:0] origin_col;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [2:0] cell_row;
    logic [7:0] cell_col;
    logic [7:0] cell_code;
    logic       last_cell;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_GLYPH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit_strip;
    logic emit_glyph;
  } bdf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic plan_strip;
    logic glyph_pend;
    logic strip_end;
    logic glyph_end;
    logic out_free;
  } bdf_status_t;

  // Map a character to its glyph slot
  function automatic logic [3:0] glyph_idx(input logic [7:0] ch);
    logic [7:0] diff;
    diff = ch - CHAR_ZERO;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) return diff[3:0];
    else if (ch == CHAR_C) return GLYPH_C;
    else if (ch == CHAR_F) return GLYPH_F;
    else if (ch == CHAR_L) return GLYPH_L;
    else if (ch == CHAR_G) return GLYPH_G;
    else return GLYPH_BLANK;
  endfunction

  // Map a character to its punctuation strip
  function automatic logic [1:0] punct_idx(input logic [7:0] ch);
    if (ch == CHAR_DOT) return PUNCT_DOT;
    else if (ch == CHAR_COLON) return PUNCT_COLON;
    else return PUNCT_NONE;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bdf_ctrl.sv =====
// Controller state machine: sequences the strip and glyph phases of one item.
`default_nettype none

module bdf_ctrl import bdf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire bdf_status_t status_i,
  output bdf_cmd_t         cmd_o
);

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.plan_strip ? ST_STRIP : ST_GLYPH;
        end
      end
      ST_STRIP: begin
        if (status_i.out_free && status_i.strip_end) begin
          state_d = status_i.glyph_pend ? ST_GLYPH : ST_IDLE;
        end
      end
      ST_GLYPH: begin
        if (status_i.out_free && status_i.glyph_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_STRIP: cmd_o.emit_strip = status_i.out_free;
      ST_GLYPH: cmd_o.emit_glyph = status_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A cell is only produced into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_strip || cmd_o.emit_glyph) |-> status_i.out_free)
    else $error("cell emitted while output register busy");

  // An accepted item always starts drawing
  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_STRIP || state_q == ST_GLYPH))
    else $error("accepted item did not start drawing");

  // The last glyph cell returns to idle
  a_glyph_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_glyph && status_i.glyph_end) |=> state_q == ST_IDLE)
    else $error("glyph finished but controller not idle");

  // A strip that ends the item returns to idle
  a_strip_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_strip && status_i.strip_end && !status_i.glyph_pend)
      |=> state_q == ST_IDLE)
    else $error("strip finished item but controller not idle");

endmodule

`default_nettype wire

// ===== rtl/bdf_datapath.sv =====
// Datapath: string state, cursor, cell counters, font lookup and output register.
`default_nettype none

module bdf_datapath import bdf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_font_mode_i,
  input  wire in_item_t    in_data_i,
  input  wire bdf_cmd_t    cmd_i,
  output bdf_status_t      status_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o
);

  logic       font_q;
  logic       seen_first_q, after_punct_q;
  logic [1:0] base_row_q;
  logic [7:0] cursor_q;
  logic [1:0] pidx_q;
  logic [3:0] gidx_q;
  logic       glyph_pend_q;
  logic [1:0] row_q, col_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic [1:0] in_pidx;
  logic       plan_strip, plan_glyph;
  logic [1:0] rows_last, cols_last;
  logic       strip_end, glyph_end;
  logic [3:0] idx3x4;
  logic [7:0] strip_code, glyph_code;
  logic [2:0] cell_row;

  // Decode the incoming item against the string state
  always_comb begin
    in_pidx    = punct_idx(in_data_i.text_char);
    plan_strip = !after_punct_q && (in_pidx != PUNCT_NONE || seen_first_q);
    plan_glyph = after_punct_q || in_pidx == PUNCT_NONE;
  end

  // Cell position within the current strip or glyph
  always_comb begin
    rows_last  = font_q ? 2'd3 : 2'd1;
    cols_last  = font_q ? 2'd2 : 2'd1;
    strip_end  = row_q == rows_last;
    glyph_end  = strip_end && col_q == cols_last;
    idx3x4     = {1'b0, row_q, 1'b0} + {2'b00, row_q} + {2'b00, col_q};
    strip_code = font_q ? P3X4[pidx_q][row_q] : P2X2[pidx_q][row_q[0]];
    glyph_code = font_q ? G3X4[gidx_q][idx3x4] : G2X2[gidx_q][{row_q[0], col_q[0]}];
    cell_row   = {1'b0, base_row_q} + {1'b0, row_q};
  end

  // Font mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_q <= 1'b0;
    end else if (cfg_valid_i) begin
      font_q <= cfg_font_mode_i;
    end
  end

  // String state, cursor and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_first_q  <= 1'b0;
      after_punct_q <= 1'b0;
      base_row_q    <= '0;
      cursor_q      <= '0;
      pidx_q        <= PUNCT_NONE;
      gidx_q        <= GLYPH_BLANK;
      glyph_pend_q  <= 1'b0;
      row_q         <= '0;
      col_q         <= '0;
    end else if (cmd_i.load) begin
      if (!seen_first_q) begin
        base_row_q <= in_data_i.origin_row;
        cursor_q   <= in_data_i.origin_col;
      end
      pidx_q        <= in_pidx;
      gidx_q        <= glyph_idx(in_data_i.text_char);
      glyph_pend_q  <= plan_glyph;
      row_q         <= '0;
      col_q         <= '0;
      seen_first_q  <= !in_data_i.last_char;
      after_punct_q <= !in_data_i.last_char && !after_punct_q && in_pidx != PUNCT_NONE;
    end else if (cmd_i.emit_strip) begin
      if (strip_end) begin
        row_q    <= '0;
        cursor_q <= cursor_q + 8'd1;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end else if (cmd_i.emit_glyph) begin
      if (glyph_end) begin
        row_q    <= '0;
        col_q    <= '0;
        cursor_q <= cursor_q + {6'd0, cols_last} + 8'd1;
      end else if (col_q == cols_last) begin
        col_q <= '0;
        row_q <= row_q + 2'd1;
      end else begin
        col_q <= col_q + 2'd1;
      end
    end
  end

  // Output valid: set on a new cell, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_strip || cmd_i.emit_glyph) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_strip) begin
      out_q.cell_row  <= cell_row;
      out_q.cell_col  <= cursor_q;
      out_q.cell_code <= strip_code;
      out_q.last_cell <= strip_end && !glyph_pend_q;
    end else if (cmd_i.emit_glyph) begin
      out_q.cell_row  <= cell_row;
      out_q.cell_col  <= cursor_q + {6'd0, col_q};
      out_q.cell_code <= glyph_code;
      out_q.last_cell <= glyph_end;
    end
  end

  always_comb begin
    status_o.plan_strip = plan_strip;
    status_o.glyph_pend = glyph_pend_q;
    status_o.strip_end  = strip_end;
    status_o.glyph_end  = glyph_end;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/big_digit_font_renderer.sv =====
// Top level of the big digit font renderer: controller, datapath and config port.
`default_nettype none

// Draws a text string, one character per input item, as large glyphs on a
// character LCD and emits one cell write (row, column, code) per output item.
// font_mode selects 2x2 glyphs (4 cells) or 3x4 glyphs (12 cells); a '.' or ':'
// becomes a one-column strip of 2 or 4 cells, and a blank strip separates glyphs,
// so one character yields 2 to 16 cells, flagged last_cell on the final one.
// One cell is produced per clock from the output register while the output side
// does not stall; the next character is taken only once the controller is back
// in idle. origin_row and origin_col are sampled on the first character of a
// string; last_char ends the string. Write font_mode only while idle.
module big_digit_font_renderer import bdf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     cfg_font_mode_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  bdf_cmd_t    cmd;
  bdf_status_t status;
  logic        cfg_write;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  bdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_write),
    .cfg_font_mode_i (cfg_font_mode_i),
    .in_data_i       (in_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_o      (out_data_o)
  );

endmodule

`default_nettype wire
